[rtl/srt_pkg.sv]
// ---------------------------------------------------------------------------
// srt_pkg: shared types and constants for the sorted record table
// Record layout, command and status codes, and the name helper functions.
// ---------------------------------------------------------------------------
package srt_pkg;

  localparam int DEPTH_DEF  = 16;
  localparam int NAME_BYTES = 19;

  localparam logic [2:0] OP_INSERT    = 3'd0;
  localparam logic [2:0] OP_LIST_FWD  = 3'd1;
  localparam logic [2:0] OP_LIST_REV  = 3'd2;
  localparam logic [2:0] OP_SORT_NAME = 3'd3;
  localparam logic [2:0] OP_SORT_ID   = 3'd4;
  localparam logic [2:0] OP_DELETE    = 3'd5;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_DUP   = 3'd1;
  localparam logic [2:0] ST_FULL  = 3'd2;
  localparam logic [2:0] ST_MISS  = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;

  typedef struct packed {
    logic signed [31:0] id;
    logic [63:0]        name_low;
    logic [63:0]        name_mid;
    logic [23:0]        name_high;
  } rec_t;

  // zero every byte from the first zero byte on
  function automatic logic [8*NAME_BYTES-1:0] norm_name(input logic [63:0] lo,
                                                        input logic [63:0] mid,
                                                        input logic [23:0] hi);
    logic [8*NAME_BYTES-1:0] raw;
    logic [8*NAME_BYTES-1:0] res;
    logic                    ended;
    raw   = {hi, mid, lo};
    res   = '0;
    ended = 1'b0;
    for (int k = 0; k < NAME_BYTES; k++) begin
      if (raw[8*k +: 8] == 8'd0) ended = 1'b1;
      if (!ended) res[8*k +: 8] = raw[8*k +: 8];
    end
    return res;
  endfunction

  // byte 0 most significant, sign bits flipped: unsigned order = signed byte order
  function automatic logic [8*NAME_BYTES-1:0] name_key(input rec_t r);
    logic [8*NAME_BYTES-1:0] raw;
    logic [8*NAME_BYTES-1:0] key;
    raw = {r.name_high, r.name_mid, r.name_low};
    key = '0;
    for (int k = 0; k < NAME_BYTES; k++) begin
      key[8*(NAME_BYTES-1-k) +: 8] = raw[8*k +: 8] ^ 8'h80;
    end
    return key;
  endfunction

endpackage

[rtl/srt_if.sv]
// ---------------------------------------------------------------------------
// srt_req_if / srt_rsp_if: command and result channels
// Valid/ready channels carrying one command word or one result word.
// ---------------------------------------------------------------------------
interface srt_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         op;
  logic signed [31:0] id;
  logic [63:0]        name_low;
  logic [63:0]        name_mid;
  logic [23:0]        name_high;

  modport source (output valid, op, id, name_low, name_mid, name_high, input ready);
  modport sink   (input valid, op, id, name_low, name_mid, name_high, output ready);
endinterface

interface srt_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] rec_id;
  logic [63:0]        rec_name_low;
  logic [63:0]        rec_name_mid;
  logic [23:0]        rec_name_high;
  logic [2:0]         status;
  logic               last;

  modport source (output valid, rec_id, rec_name_low, rec_name_mid, rec_name_high,
                  status, last, input ready);
  modport sink   (input valid, rec_id, rec_name_low, rec_name_mid, rec_name_high,
                  status, last, output ready);
endinterface

[rtl/srt_ram.sv]
// ---------------------------------------------------------------------------
// srt_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module srt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/sorted_record_table.sv]
// ---------------------------------------------------------------------------
// sorted_record_table: ordered table of ID/name records
// Insert, delete, list and exchange sort over a record RAM, one RAM access
// per step under a small sequencer.
// ---------------------------------------------------------------------------
//  channel | dir | word                                   | accepted when
//  req     | in  | op, id, name_low/mid/high              | valid && ready
//  rsp     | out | rec_id, rec_name_*, status, last       | valid && ready
//
//  Insert: a scan of all entries, a shift of each later entry, then a place.
//  Delete: a scan of all entries, then a shift of each later entry to close the gap.
//  List: a read and a result word per entry. Sort: exchange passes through the
//  one compare unit. Simple answers: one status word. All reads share one RAM port.
//  req.ready is high only when idle; rsp stalls hold the sequencer.
//  Reset empties the table at once; no clearing pass.
// ---------------------------------------------------------------------------
module sorted_record_table #(
  parameter int DEPTH = srt_pkg::DEPTH_DEF
) (
  input logic         clk,
  input logic         rst,
  srt_req_if.sink     req,
  srt_rsp_if.source   rsp
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] ONE  = CW'(1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_SCAN_RD  = 14'b00000000000010,
    S_SCAN_CHK = 14'b00000000000100,
    S_SHIFT_RD = 14'b00000000001000,
    S_SHIFT_WR = 14'b00000000010000,
    S_PLACE    = 14'b00000000100000,
    S_LIST_RD  = 14'b00000001000000,
    S_LIST_OUT = 14'b00000010000000,
    S_SORT_RDI = 14'b00000100000000,
    S_SORT_LDI = 14'b00001000000000,
    S_SORT_RDJ = 14'b00010000000000,
    S_SORT_CMP = 14'b00100000000000,
    S_SORT_WRI = 14'b01000000000000,
    S_DONE     = 14'b10000000000000
  } state_t;

  state_t              state;
  logic [CW-1:0]       cnt;
  logic [CW-1:0]       idx;
  logic [CW-1:0]       jdx;
  logic [CW-1:0]       pos;
  logic [CW-1:0]       k;
  logic [CW-1:0]       rd_idx;
  logic                dup;
  logic [2:0]          op_r;
  logic [2:0]          st_r;
  srt_pkg::rec_t       new_rec;
  srt_pkg::rec_t       hold;
  srt_pkg::rec_t       rd_rec;
  logic [$bits(srt_pkg::rec_t)-1:0] rd_data;

  logic                wr_en;
  logic [CW-1:0]       wr_idx;
  srt_pkg::rec_t       wr_rec;

  logic                ov;
  logic                ov_set;
  logic                out_free;
  logic                hit;
  logic                gt_new;
  logic                sort_gt;
  logic [CW-1:0]       pos_upd;
  logic [8*srt_pkg::NAME_BYTES-1:0] nm;

  srt_ram #(.WIDTH($bits(srt_pkg::rec_t)), .DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_idx[IW-1:0]),
    .wr_data (wr_rec),
    .rd_addr (rd_idx[IW-1:0]),
    .rd_data (rd_data)
  );

  assign rd_rec    = srt_pkg::rec_t'(rd_data);
  assign out_free  = !ov || rsp.ready;
  assign ov_set    = out_free && (state == S_LIST_OUT || state == S_DONE);
  assign req.ready = (state == S_IDLE);
  assign rsp.valid = ov;
  assign nm        = srt_pkg::norm_name(req.name_low, req.name_mid, req.name_high);

  assign hit     = (rd_rec.id == new_rec.id);
  assign gt_new  = (rd_rec.id > new_rec.id);
  always_comb begin
    pos_upd = pos;
    if (op_r == srt_pkg::OP_INSERT) begin
      if (pos == cnt && gt_new) pos_upd = idx;
    end else begin
      if (pos == cnt && hit) pos_upd = idx;
    end
  end

  assign sort_gt = (op_r == srt_pkg::OP_SORT_NAME) ?
                   (srt_pkg::name_key(hold) > srt_pkg::name_key(rd_rec)) :
                   (hold.id > rd_rec.id);

  always_comb begin
    wr_en  = 1'b0;
    wr_idx = k;
    wr_rec = rd_rec;
    unique case (state)
      S_SHIFT_WR: begin
        wr_en = 1'b1;
      end
      S_PLACE: begin
        wr_en  = 1'b1;
        wr_idx = pos;
        wr_rec = new_rec;
      end
      S_SORT_CMP: begin
        wr_en  = sort_gt;
        wr_idx = jdx;
        wr_rec = hold;
      end
      S_SORT_WRI: begin
        wr_en  = 1'b1;
        wr_idx = idx;
        wr_rec = hold;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      ov    <= 1'b0;
    end else begin
      if (ov_set) ov <= 1'b1;
      else if (rsp.ready) ov <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            op_r              <= req.op;
            new_rec.id        <= req.id;
            new_rec.name_low  <= nm[63:0];
            new_rec.name_mid  <= nm[127:64];
            new_rec.name_high <= nm[151:128];
            dup               <= 1'b0;
            pos               <= cnt;
            idx               <= '0;
            rd_idx            <= (req.op == srt_pkg::OP_LIST_REV) ? cnt - ONE : '0;
            priority if (req.op == srt_pkg::OP_INSERT) begin
              if (cnt == '0) begin
                state <= S_PLACE;
              end else begin
                state <= S_SCAN_RD;
              end
            end else if (req.op > srt_pkg::OP_DELETE) begin
              state <= S_IDLE;
            end else if (cnt == '0) begin
              st_r  <= srt_pkg::ST_EMPTY;
              state <= S_DONE;
            end else if (req.op == srt_pkg::OP_LIST_FWD) begin
              state <= S_LIST_RD;
            end else if (req.op == srt_pkg::OP_LIST_REV) begin
              state <= S_LIST_RD;
            end else if (req.op == srt_pkg::OP_DELETE) begin
              state <= S_SCAN_RD;
            end else begin
              if (cnt == ONE) begin
                st_r  <= srt_pkg::ST_OK;
                state <= S_DONE;
              end else begin
                state <= S_SORT_RDI;
              end
            end
          end
        end
        S_SCAN_RD: state <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          pos <= pos_upd;
          if (hit) dup <= 1'b1;
          if (idx + ONE < cnt) begin
            idx    <= idx + ONE;
            rd_idx <= idx + ONE;
            state  <= S_SCAN_RD;
          end else if (op_r == srt_pkg::OP_INSERT) begin
            if (dup || hit) begin
              st_r  <= srt_pkg::ST_DUP;
              state <= S_DONE;
            end else if (cnt == FULL) begin
              st_r  <= srt_pkg::ST_FULL;
              state <= S_DONE;
            end else begin
              k <= cnt;
              if (cnt > pos_upd) begin
                rd_idx <= cnt - ONE;
                state  <= S_SHIFT_RD;
              end else begin
                state <= S_PLACE;
              end
            end
          end else begin
            if (pos_upd == cnt) begin
              st_r  <= srt_pkg::ST_MISS;
              state <= S_DONE;
            end else begin
              k <= pos_upd;
              if (pos_upd + ONE < cnt) begin
                rd_idx <= pos_upd + ONE;
                state  <= S_SHIFT_RD;
              end else begin
                cnt   <= cnt - ONE;
                st_r  <= srt_pkg::ST_OK;
                state <= S_DONE;
              end
            end
          end
        end
        S_SHIFT_RD: state <= S_SHIFT_WR;
        S_SHIFT_WR: begin
          if (op_r == srt_pkg::OP_INSERT) begin
            k <= k - ONE;
            if (k - ONE > pos) begin
              rd_idx <= k - ONE - ONE;
              state  <= S_SHIFT_RD;
            end else begin
              state <= S_PLACE;
            end
          end else begin
            k <= k + ONE;
            if (k + ONE + ONE < cnt) begin
              rd_idx <= k + ONE + ONE;
              state  <= S_SHIFT_RD;
            end else begin
              cnt   <= cnt - ONE;
              st_r  <= srt_pkg::ST_OK;
              state <= S_DONE;
            end
          end
        end
        S_PLACE: begin
          cnt   <= cnt + ONE;
          st_r  <= srt_pkg::ST_OK;
          state <= S_DONE;
        end
        S_LIST_RD: state <= S_LIST_OUT;
        S_LIST_OUT: begin
          if (out_free) begin
            rsp.rec_id        <= rd_rec.id;
            rsp.rec_name_low  <= rd_rec.name_low;
            rsp.rec_name_mid  <= rd_rec.name_mid;
            rsp.rec_name_high <= rd_rec.name_high;
            rsp.status        <= srt_pkg::ST_OK;
            rsp.last          <= (idx + ONE == cnt);
            if (idx + ONE == cnt) begin
              state <= S_IDLE;
            end else begin
              idx    <= idx + ONE;
              rd_idx <= (op_r == srt_pkg::OP_LIST_FWD) ? idx + ONE : cnt - ONE - ONE - idx;
              state  <= S_LIST_RD;
            end
          end
        end
        S_SORT_RDI: state <= S_SORT_LDI;
        S_SORT_LDI: begin
          hold   <= rd_rec;
          jdx    <= idx + ONE;
          rd_idx <= idx + ONE;
          state  <= S_SORT_RDJ;
        end
        S_SORT_RDJ: state <= S_SORT_CMP;
        S_SORT_CMP: begin
          if (sort_gt) hold <= rd_rec;
          if (jdx + ONE < cnt) begin
            jdx    <= jdx + ONE;
            rd_idx <= jdx + ONE;
            state  <= S_SORT_RDJ;
          end else begin
            state <= S_SORT_WRI;
          end
        end
        S_SORT_WRI: begin
          if (idx + ONE + ONE < cnt) begin
            idx    <= idx + ONE;
            rd_idx <= idx + ONE;
            state  <= S_SORT_RDI;
          end else begin
            st_r  <= srt_pkg::ST_OK;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            rsp.rec_id        <= '0;
            rsp.rec_name_low  <= '0;
            rsp.rec_name_mid  <= '0;
            rsp.rec_name_high <= '0;
            rsp.status        <= st_r;
            rsp.last          <= 1'b1;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/srt_checker.sv]
// ---------------------------------------------------------------------------
// srt_checker: port-level checks on the sorted record table
// Watches the command and result channels only.
// ---------------------------------------------------------------------------
module srt_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic signed [31:0] rsp_rec_id,
  input logic [2:0]         rsp_status,
  input logic               rsp_last
);

  // a list in flight blocks new commands
  a_list_blocks: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_last |-> !req_ready)
    else $error("command taken mid list");

  a_flag_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != srt_pkg::ST_OK |-> rsp_last)
    else $error("flagged word not last");

  a_flag_norec: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != srt_pkg::ST_OK |-> rsp_rec_id == '0)
    else $error("flagged word carries a record");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result word after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result word dropped");

endmodule

bind sorted_record_table srt_checker u_srt_checker (
  .clk        (clk),
  .rst        (rst),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_rec_id (rsp.rec_id),
  .rsp_status (rsp.status),
  .rsp_last   (rsp.last)
);

[dv/srt_tb_if.sv]
// ---------------------------------------------------------------------------
// srt_tb_if: testbench flag
// A single flag, hold_off, shared between the stimulus processes.
// ---------------------------------------------------------------------------
interface srt_tb_flags_if;
  logic hold_off;
endinterface

[dv/srt_checker.sv]
// ---------------------------------------------------------------------------
// srt_scoreboard: record table predictor and result comparator
// Watches the command and result channels, keeps its own copy of the
// table, queues the expected result words and compares each one accepted.
// ---------------------------------------------------------------------------
module srt_scoreboard #(
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  srt_req_if   req,
  srt_rsp_if   rsp,
  output int   errors,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] id;
    logic [63:0]        nlo;
    logic [63:0]        nmid;
    logic [23:0]        nhi;
    logic [2:0]         status;
    logic               last;
  } word_t;

  srt_pkg::rec_t table_q[$];
  word_t         answers[$];

  function automatic logic [151:0] clean_name(logic [63:0] lo, logic [63:0] mid,
                                              logic [23:0] hi);
    logic [151:0] raw;
    logic [151:0] res;
    logic         ended;
    raw   = {hi, mid, lo};
    res   = '0;
    ended = 1'b0;
    for (int k = 0; k < 19; k++) begin
      if (raw[8*k +: 8] == 8'd0) ended = 1'b1;
      if (!ended) res[8*k +: 8] = raw[8*k +: 8];
    end
    return res;
  endfunction

  function automatic bit name_gt(srt_pkg::rec_t a, srt_pkg::rec_t b);
    logic [151:0] x;
    logic [151:0] y;
    logic signed [7:0] p;
    logic signed [7:0] q;
    x = {a.name_high, a.name_mid, a.name_low};
    y = {b.name_high, b.name_mid, b.name_low};
    for (int k = 0; k < 19; k++) begin
      p = x[8*k +: 8];
      q = y[8*k +: 8];
      if (p != q) return p > q;
    end
    return 1'b0;
  endfunction

  function automatic void push_status(logic [2:0] st);
    answers.push_back('{'0, '0, '0, '0, st, 1'b1});
  endfunction

  function automatic void apply_command(logic [2:0] op, logic signed [31:0] id,
                                        logic [63:0] lo, logic [63:0] mid,
                                        logic [23:0] hi);
    int n;
    int pos;
    int at;
    srt_pkg::rec_t r;
    srt_pkg::rec_t t;
    logic [151:0] nm;
    bit gt;
    n = table_q.size();
    if (op == srt_pkg::OP_INSERT) begin
      foreach (table_q[i]) if (table_q[i].id == id) begin
        push_status(srt_pkg::ST_DUP);
        return;
      end
      if (n >= DEPTH) begin
        push_status(srt_pkg::ST_FULL);
        return;
      end
      nm = clean_name(lo, mid, hi);
      r.id = id;
      {r.name_high, r.name_mid, r.name_low} = nm;
      pos = n;
      for (int i = 0; i < n; i++) if (table_q[i].id > id) begin
        pos = i;
        break;
      end
      table_q.insert(pos, r);
      push_status(srt_pkg::ST_OK);
      return;
    end
    if (op > srt_pkg::OP_DELETE) return;
    if (n == 0) begin
      push_status(srt_pkg::ST_EMPTY);
      return;
    end
    case (op)
      srt_pkg::OP_LIST_FWD, srt_pkg::OP_LIST_REV: begin
        for (int i = 0; i < n; i++) begin
          t = table_q[(op == srt_pkg::OP_LIST_FWD) ? i : n - 1 - i];
          answers.push_back('{t.id, t.name_low, t.name_mid, t.name_high,
                              srt_pkg::ST_OK, i == n - 1});
        end
      end
      srt_pkg::OP_SORT_NAME, srt_pkg::OP_SORT_ID: begin
        for (int i = 0; i + 1 < n; i++)
          for (int j = i + 1; j < n; j++) begin
            gt = (op == srt_pkg::OP_SORT_NAME) ? name_gt(table_q[i], table_q[j])
                                               : table_q[i].id > table_q[j].id;
            if (gt) begin
              t = table_q[i];
              table_q[i] = table_q[j];
              table_q[j] = t;
            end
          end
        push_status(srt_pkg::ST_OK);
      end
      default: begin
        at = -1;
        for (int i = 0; i < n; i++) if (table_q[i].id == id) begin
          at = i;
          break;
        end
        if (at < 0) push_status(srt_pkg::ST_MISS);
        else begin
          table_q.delete(at);
          push_status(srt_pkg::ST_OK);
        end
      end
    endcase
  endfunction

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    word_t e;
    word_t got;
    if (!rst) begin
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.rec_id, rsp.rec_name_low, rsp.rec_name_mid, rsp.rec_name_high,
                rsp.status, rsp.last};
        if (answers.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, got);
          errors++;
        end else begin
          e = answers.pop_front();
          if (e.id !== got.id) begin
            $display("%0t: rec_id exp %h got %h", $time, e.id, got.id); errors++;
          end
          if (e.nlo !== got.nlo) begin
            $display("%0t: rec_name_low exp %h got %h", $time, e.nlo, got.nlo); errors++;
          end
          if (e.nmid !== got.nmid) begin
            $display("%0t: rec_name_mid exp %h got %h", $time, e.nmid, got.nmid);
            errors++;
          end
          if (e.nhi !== got.nhi) begin
            $display("%0t: rec_name_high exp %h got %h", $time, e.nhi, got.nhi); errors++;
          end
          if (e.status !== got.status) begin
            $display("%0t: status exp %0d got %0d", $time, e.status, got.status); errors++;
          end
          if (e.last !== got.last) begin
            $display("%0t: last exp %b got %b", $time, e.last, got.last); errors++;
          end
        end
      end
      if (req.valid && req.ready)
        apply_command(req.op, req.id, req.name_low, req.name_mid, req.name_high);
    end
    pending = answers.size();
  end
endmodule

[dv/testbench.sv]
// ---------------------------------------------------------------------------
// testbench: sorted record table stimulus and verdict
// Directed commands over the table's corner cases, then random phases of
// mostly inserts and deletes with a narrow key set, under varied sender
// and receiver idling, with a long receiver hold-off and a drain pause.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   send_idle;
  int   recv_stall;
  int   id_pool[8];

  srt_req_if      req();
  srt_rsp_if      rsp();
  srt_tb_flags_if flags();

  sorted_record_table #(.DEPTH(16)) DUT (.clk(clk), .rst(rst), .req(req), .rsp(rsp));
  srt_scoreboard #(.DEPTH(16)) u_checker (.clk(clk), .rst(rst), .req(req), .rsp(rsp),
                                          .errors(errors), .pending(pending));

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("** sorted_record_table: FAILED **");
    $finish;
  end

  always @(negedge clk) begin
    if (rst || flags.hold_off) rsp.ready <= 1'b0;
    else rsp.ready <= ($urandom_range(99) >= recv_stall);
  end

  // valid stays up after the accepting edge until the next negedge decides
  task automatic send_word(logic [2:0] op, logic signed [31:0] id, logic [63:0] lo,
                           logic [63:0] mid, logic [23:0] hi);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid     <= 1'b1;
    req.op        <= op;
    req.id        <= id;
    req.name_low  <= lo;
    req.name_mid  <= mid;
    req.name_high <= hi;
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic release_req();
    @(negedge clk);
    req.valid <= 1'b0;
  endtask

  task automatic rand_name(output logic [63:0] lo, output logic [63:0] mid,
                           output logic [23:0] hi);
    logic [151:0] nm;
    int cut;
    nm = 152'({$urandom, $urandom, $urandom, $urandom, $urandom});
    case ($urandom_range(3))
      0: nm = nm & {19{8'h03}};
      1: begin
        cut = $urandom_range(18);
        nm[8*cut +: 8] = 8'h00;
      end
      default: ;
    endcase
    {hi, mid, lo} = nm;
  endtask

  task automatic random_word(bit wide);
    logic [2:0] op;
    logic signed [31:0] id;
    logic [63:0] lo;
    logic [63:0] mid;
    logic [23:0] hi;
    int p;
    p  = $urandom_range(99);
    op = p < 45 ? srt_pkg::OP_INSERT : p < 55 ? srt_pkg::OP_LIST_FWD :
         p < 62 ? srt_pkg::OP_LIST_REV : p < 67 ? srt_pkg::OP_SORT_NAME :
         p < 72 ? srt_pkg::OP_SORT_ID : p < 97 ? srt_pkg::OP_DELETE :
         3'($urandom_range(6, 7));
    id = (wide || $urandom_range(4) == 0) ? $urandom : id_pool[$urandom_range(7)];
    rand_name(lo, mid, hi);
    send_word(op, id, lo, mid, hi);
  endtask

  task automatic drain();
    release_req();
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  initial begin
    rst = 1'b1;
    flags.hold_off = 1'b0;
    send_idle = 0;
    recv_stall = 0;
    req.valid = 1'b0;
    req.op = srt_pkg::OP_INSERT;
    req.id = '0;
    req.name_low = '0;
    req.name_mid = '0;
    req.name_high = '0;
    rsp.ready = 1'b0;
    foreach (id_pool[i]) id_pool[i] = $urandom;
    id_pool[0] = 32'sh8000_0000;
    id_pool[1] = 32'sh7fff_ffff;
    id_pool[2] = 0;
    id_pool[3] = -1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_word(srt_pkg::OP_LIST_FWD, '0, '0, '0, '0);
    send_word(srt_pkg::OP_SORT_NAME, '0, '0, '0, '0);
    send_word(srt_pkg::OP_SORT_ID, '0, '0, '0, '0);
    send_word(srt_pkg::OP_DELETE, 32'sd5, '0, '0, '0);
    send_word(srt_pkg::OP_INSERT, 32'sh7fff_ffff, '1, '1, '1);
    send_word(srt_pkg::OP_INSERT, 32'sh8000_0000, 64'h8081_ff00_4142, '1, '1);
    send_word(srt_pkg::OP_INSERT, '0, 64'h0043_4241, '1, 24'h7f);
    send_word(srt_pkg::OP_INSERT, -32'sd1, 64'h0043_4241, '0, '0);
    send_word(srt_pkg::OP_INSERT, '0, '0, '0, '0);
    send_word(3'd6, 32'sd1, 64'd1, 64'd1, 24'd1);
    send_word(3'd7, 32'sd2, 64'd2, 64'd2, 24'd2);
    send_word(srt_pkg::OP_SORT_NAME, '0, '0, '0, '0);
    send_word(srt_pkg::OP_LIST_FWD, '0, '0, '0, '0);
    send_word(srt_pkg::OP_SORT_ID, '0, '0, '0, '0);
    send_word(srt_pkg::OP_LIST_REV, '0, '0, '0, '0);
    send_word(srt_pkg::OP_DELETE, 32'sd1234, '0, '0, '0);
    send_word(srt_pkg::OP_DELETE, 32'sh8000_0000, '0, '0, '0);
    for (int i = 0; i < 14; i++)
      send_word(srt_pkg::OP_INSERT, 32'(i + 10), 64'h41 + 64'(i), '0, '0);
    send_word(srt_pkg::OP_INSERT, 32'sd99, 64'd1, '0, '0);
    send_word(srt_pkg::OP_LIST_FWD, '0, '0, '0, '0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle  = (ph == 1 || ph == 3) ? (ph == 1 ? 47 : 25) : 0;
      recv_stall = (ph == 2 || ph == 3) ? (ph == 2 ? 47 : 25) : 0;
      for (int k = 0; k < 100; k++) random_word(ph == 0 && k < 20);
      if (ph == 1) begin
        flags.hold_off = 1'b1;
        fork
          begin
            repeat (400) @(negedge clk);
            flags.hold_off = 1'b0;
          end
          for (int k = 0; k < 6; k++) random_word(1'b0);
        join
      end
      drain();
    end
    if (errors == 0) $display("** sorted_record_table: PASSED **");
    else $display("** sorted_record_table: FAILED **");
    $finish;
  end
endmodule
